// ===== design/tphd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tphd_pkg - shared types and constants of the touch gesture classifier
// Payload structs, gesture codes, register map and reset values.
// ----------------------------------------------------------------------------
package tphd_pkg;

  // payload and register widths
  localparam int WORD_W         = 32;
  localparam int CFG_W          = 12;
  localparam int CFG_DW         = 32;
  localparam int CFG_AW         = 4;
  localparam int TIME_WIDTH_DEF = 12;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_POLL_PERIOD = 2'd0;
  localparam logic [1:0] REG_LOCK_TIME   = 2'd1;
  localparam logic [1:0] REG_DRAG_TIME   = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] POLL_PERIOD_RST = 12'd33;
  localparam logic [CFG_W-1:0] LOCK_TIME_RST   = 12'd30;
  localparam logic [CFG_W-1:0] DRAG_TIME_RST   = 12'd120;

  // gesture codes
  localparam logic [1:0] GC_PRESSED = 2'd0;
  localparam logic [1:0] GC_LOCK    = 2'd1;
  localparam logic [1:0] GC_DRAG    = 2'd2;
  localparam logic [1:0] GC_RELEASE = 2'd3;

  typedef struct packed {
    logic              ms_strobe;
    logic              touched;
    logic [WORD_W-1:0] touch_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        gesture_code;
    logic [WORD_W-1:0] gesture_word;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/touch_press_hold_drag_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_press_hold_drag_classifier - press / lock / drag / release detector
// Samples the touch flag once per poll period of millisecond strobes and
// reports gestures with the touch word.
// ----------------------------------------------------------------------------
// Takes one input transfer every clock while in_stall is low. Each transfer
// is captured in an input register, classified in one pass against the poll
// counter, press timer and gesture phase, and the result (if any) lands in
// the output register. While a result waits on out_stall the input register
// keeps taking transfers; in_stall rises only when the held item has a
// gesture to report and the output register is still full. Items without a
// millisecond strobe never produce a result. Registers at paddr 0x0 (poll
// period), 0x4 (lock time) and 0x8 (drag time), 12 bits each, are to be
// written only while idle by the user; the block does not enforce it.
module touch_press_hold_drag_classifier
  import tphd_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire in_item_t          in_data,
  // result channel
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      out_item_t         out_data,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready
);

  localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

  typedef enum logic [3:0] {
    PH_EMPTY   = 4'b0001,
    PH_PRESSED = 4'b0010,
    PH_LOCK    = 4'b0100,
    PH_DRAG    = 4'b1000
  } phase_t;

  // configuration registers
  logic [CFG_W-1:0]      poll_period_r, lock_time_r, drag_time_r;
  // input stage
  logic                  in_valid_r;
  in_item_t              in_r;
  // classifier state
  logic [TIME_WIDTH-1:0] poll_cnt_r, poll_cnt_nxt;
  logic [TIME_WIDTH-1:0] press_tmr_r, press_tmr_nxt;
  logic                  was_touched_r, was_touched_nxt;
  logic [WORD_W-1:0]     last_word_r, last_word_nxt;
  phase_t                phase_r, phase_nxt;
  // output stage
  logic                  out_valid_r;
  out_item_t             out_r, res_nxt;

  logic                  emit;
  logic                  proc_go;
  logic                  cfg_wr;
  logic [TIME_WIDTH-1:0] tmr_inc, pc_inc;
  logic [CMP_W-1:0]      period_ext, pc_ext, tmr_ext, lock_ext, drag_ext;

  // APB write strobe and readback
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      REG_POLL_PERIOD: prdata = CFG_DW'(poll_period_r);
      REG_LOCK_TIME:   prdata = CFG_DW'(lock_time_r);
      REG_DRAG_TIME:   prdata = CFG_DW'(drag_time_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_period_r <= POLL_PERIOD_RST;
      lock_time_r   <= LOCK_TIME_RST;
      drag_time_r   <= DRAG_TIME_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_POLL_PERIOD: poll_period_r <= pwdata[CFG_W-1:0];
        REG_LOCK_TIME:   lock_time_r   <= pwdata[CFG_W-1:0];
        REG_DRAG_TIME:   drag_time_r   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // held item moves on unless it has a result and the output is blocked
  assign proc_go  = in_valid_r & (~emit | ~(out_valid_r & out_stall));
  assign in_stall = in_valid_r & ~proc_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // saturating increments and compare operands
  assign tmr_inc    = was_touched_r ?
                      ((press_tmr_r == '1) ? press_tmr_r : press_tmr_r + 1'b1) :
                      press_tmr_r;
  assign pc_inc     = (poll_cnt_r == '1) ? poll_cnt_r : poll_cnt_r + 1'b1;
  assign period_ext = (poll_period_r == '0) ? CMP_W'(1) : CMP_W'(poll_period_r);
  assign pc_ext     = CMP_W'(pc_inc);
  assign tmr_ext    = CMP_W'(tmr_inc);
  assign lock_ext   = CMP_W'(lock_time_r);
  assign drag_ext   = CMP_W'(drag_time_r);

  // one-pass gesture classification
  always_comb begin
    poll_cnt_nxt    = poll_cnt_r;
    press_tmr_nxt   = press_tmr_r;
    was_touched_nxt = was_touched_r;
    last_word_nxt   = last_word_r;
    phase_nxt       = phase_r;
    emit            = 1'b0;
    res_nxt         = '{gesture_code: GC_PRESSED, gesture_word: in_r.touch_word};
    if (in_valid_r && in_r.ms_strobe) begin
      poll_cnt_nxt  = pc_inc;
      press_tmr_nxt = tmr_inc;
      if (pc_ext >= period_ext) begin
        poll_cnt_nxt    = '0;
        was_touched_nxt = in_r.touched;
        last_word_nxt   = in_r.touch_word;
        if (in_r.touched) begin
          if (!was_touched_r) begin
            press_tmr_nxt        = '0;
            phase_nxt            = PH_PRESSED;
            emit                 = 1'b1;
            res_nxt.gesture_code = GC_PRESSED;
          end else if (tmr_ext >= drag_ext) begin
            phase_nxt            = PH_DRAG;
            emit                 = 1'b1;
            res_nxt.gesture_code = GC_DRAG;
          end else if (tmr_ext >= lock_ext && phase_r != PH_LOCK) begin
            phase_nxt            = PH_LOCK;
            emit                 = 1'b1;
            res_nxt.gesture_code = GC_LOCK;
          end
        end else if (was_touched_r) begin
          // release reports the word of the previous poll
          phase_nxt            = PH_EMPTY;
          emit                 = 1'b1;
          res_nxt.gesture_code = GC_RELEASE;
          res_nxt.gesture_word = last_word_r;
        end
      end
    end
  end

  // classifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_cnt_r    <= '0;
      press_tmr_r   <= '0;
      was_touched_r <= 1'b0;
      last_word_r   <= '0;
      phase_r       <= PH_EMPTY;
    end else if (proc_go) begin
      poll_cnt_r    <= poll_cnt_nxt;
      press_tmr_r   <= press_tmr_nxt;
      was_touched_r <= was_touched_nxt;
      last_word_r   <= last_word_nxt;
      phase_r       <= phase_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && emit) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== design/tphd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tphd_checker - port-level checks of the touch gesture classifier
// Watches the channels and the register port; bound to the top level.
// ----------------------------------------------------------------------------
module tphd_checker
  import tphd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire out_item_t         out_data,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [CFG_AW-1:0] paddr,
  input wire logic [CFG_DW-1:0] pwdata,
  input wire logic [CFG_DW-1:0] prdata,
  input wire logic              pready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // input only backs up behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // poll period reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && paddr[3:2] == REG_POLL_PERIOD
    |=> (paddr[3:2] == REG_POLL_PERIOD) && !(psel && penable && pwrite)
        |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
    else $error("poll period readback mismatch");

endmodule

bind touch_press_hold_drag_classifier tphd_checker u_tphd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the touch press / hold / drag classifier
// Drives touch samples and millisecond strobes, predicts every gesture in the
// testbench and checks each result transfer in order. The register port is
// exercised with write and readback, and the run walks through several poll,
// lock and drag settings under changing amounts of idling and stalling.
// ----------------------------------------------------------------------------
module tb_top;
  import tphd_pkg::*;

  localparam int SETTLE_CYCLES = 8;  // extra wait once no gesture is owed
  localparam logic [TIME_WIDTH_DEF-1:0] TIMER_MAX = '1;

  typedef enum logic [2:0] {
    PH_EMPTY   = 3'd0,
    PH_PRESSED = 3'd1,
    PH_LOCK    = 3'd2,
    PH_DRAG    = 3'd3
  } gesture_phase_t;

  // DUT connections, all driven from time zero
  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [CFG_DW-1:0] pwdata    = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // register copies seen by the predictor
  logic [CFG_W-1:0] poll_period_cfg = POLL_PERIOD_RST;
  logic [CFG_W-1:0] lock_time_cfg   = LOCK_TIME_RST;
  logic [CFG_W-1:0] drag_time_cfg   = DRAG_TIME_RST;

  // predicted classifier state
  logic [TIME_WIDTH_DEF-1:0] ms_since_poll = '0;
  logic [TIME_WIDTH_DEF-1:0] hold_ms       = '0;
  logic                      touch_seen    = 1'b0;
  logic [WORD_W-1:0]         seen_word     = '0;
  gesture_phase_t            phase         = PH_EMPTY;

  out_item_t gesture_q[$];  // gestures still owed by the block
  out_item_t want_g;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_cnt        = 0;
  int items_sent     = 0;
  int strobes_sent   = 0;
  int gestures_seen[4];

  touch_press_hold_drag_classifier u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Gesture predictor: one call per accepted input transfer
  // --------------------------------------------------------------------------
  function automatic bit predict_gesture(input in_item_t it, output out_item_t g);
    logic              prev_touch;
    logic [WORD_W-1:0] prev_word;
    logic [CFG_W-1:0]  period;
    g = '0;
    if (!it.ms_strobe) return 1'b0;
    // timer and poll counter advance before the poll decision, saturating
    if (touch_seen && hold_ms != TIMER_MAX) hold_ms = hold_ms + 1'b1;
    if (ms_since_poll != TIMER_MAX) ms_since_poll = ms_since_poll + 1'b1;
    period = poll_period_cfg;
    if (period == '0) period = CFG_W'(1);
    if (ms_since_poll < period) return 1'b0;
    ms_since_poll = '0;
    prev_touch = touch_seen;
    prev_word  = seen_word;
    touch_seen = it.touched;
    seen_word  = it.touch_word;
    if (it.touched) begin
      if (!prev_touch) begin
        hold_ms = '0;
        phase   = PH_PRESSED;
        g = '{gesture_code: GC_PRESSED, gesture_word: it.touch_word};
        return 1'b1;
      end
      // drag wins over lock when both thresholds are met
      if (hold_ms >= drag_time_cfg) begin
        phase = PH_DRAG;
        g = '{gesture_code: GC_DRAG, gesture_word: it.touch_word};
        return 1'b1;
      end
      if (hold_ms >= lock_time_cfg && phase != PH_LOCK) begin
        phase = PH_LOCK;
        g = '{gesture_code: GC_LOCK, gesture_word: it.touch_word};
        return 1'b1;
      end
      return 1'b0;
    end
    if (prev_touch) begin
      phase = PH_EMPTY;
      g = '{gesture_code: GC_RELEASE, gesture_word: prev_word};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_hold_time(input int span);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return CFG_W'($urandom_range(span));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checker and receiver stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (gesture_q.size() == 0) begin
        $display("%0t: unexpected gesture transfer, actual code %0d word %h",
                 $time, out_data.gesture_code, out_data.gesture_word);
        err_cnt++;
      end else begin
        want_g = gesture_q.pop_front();
        if (out_data.gesture_code !== want_g.gesture_code) begin
          $display("%0t: gesture_code mismatch, expected %0d actual %0d",
                   $time, want_g.gesture_code, out_data.gesture_code);
          err_cnt++;
        end
        if (out_data.gesture_word !== want_g.gesture_word) begin
          $display("%0t: gesture_word mismatch, expected %h actual %h",
                   $time, want_g.gesture_word, out_data.gesture_word);
          err_cnt++;
        end
        gestures_seen[want_g.gesture_code]++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side: one transfer, with random idle cycles ahead of it
  // --------------------------------------------------------------------------
  task automatic send_touch_item(input bit strobe, input bit touch,
                                 input logic [WORD_W-1:0] word);
    in_item_t  it;
    out_item_t g;
    it.ms_strobe  = strobe;
    it.touched    = touch;
    it.touch_word = word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (strobe) strobes_sent++;
    if (predict_gesture(it, g)) gesture_q.push_back(g);
  endtask

  // stop sending and wait until the block has nothing left in flight
  task automatic drain_results();
    in_valid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  task automatic cfg_readback(input logic [1:0] reg_idx);
    logic [CFG_W-1:0] want;
    case (reg_idx)
      REG_POLL_PERIOD: want = poll_period_cfg;
      REG_LOCK_TIME:   want = lock_time_cfg;
      default:         want = drag_time_cfg;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CFG_W-1:0] !== want) begin
      $display("%0t: register %0d readback mismatch, expected %0d actual %0d",
               $time, reg_idx, want, prdata[CFG_W-1:0]);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic [1:0] reg_idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_POLL_PERIOD: poll_period_cfg = value;
      REG_LOCK_TIME:   lock_time_cfg   = value;
      default:         drag_time_cfg   = value;
    endcase
    cfg_readback(reg_idx);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] lock_ms,
                            input logic [CFG_W-1:0] drag_ms);
    drain_results();
    cfg_write(REG_POLL_PERIOD, period);
    cfg_write(REG_LOCK_TIME, lock_ms);
    cfg_write(REG_DRAG_TIME, drag_ms);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_register_reset();
    cfg_readback(REG_POLL_PERIOD);
    cfg_readback(REG_LOCK_TIME);
    cfg_readback(REG_DRAG_TIME);
  endtask

  // short scripted gestures: each code, word extremes, threshold corners
  task automatic test_directed_gestures();
    send_idle_pct  = 7;
    recv_stall_pct = 73;
    // poll every strobe, lock at 2 ms, drag from 4 ms
    set_timing(12'd1, 12'd2, 12'd4);
    send_touch_item(1'b0, 1'b1, 32'h1234_5678);  // no strobe: ignored
    send_touch_item(1'b1, 1'b1, '1);              // pressed
    send_touch_item(1'b0, 1'b0, 32'hDEAD_BEEF);  // no strobe: ignored
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b1, rand_word());     // lock
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b1, rand_word());     // drag
    send_touch_item(1'b1, 1'b1, '0);              // drag again
    send_touch_item(1'b1, 1'b0, '1);              // release carries previous word
    send_touch_item(1'b1, 1'b0, rand_word());
    // drag threshold below lock: lock never shows
    set_timing(12'd1, 12'd3, 12'd2);
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b0, rand_word());
    // zero period and zero thresholds
    set_timing(12'd0, 12'd0, 12'd0);
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b0, rand_word());
    // immediate lock, drag out of reach
    set_timing(12'd0, 12'd0, 12'd4095);
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b0, rand_word());
  endtask

  // raising the drag time mid-hold lets lock fire a second time
  task automatic test_relock_after_retune();
    set_timing(12'd1, 12'd2, 12'd3);
    repeat (4) send_touch_item(1'b1, 1'b1, rand_word());
    drain_results();
    cfg_write(REG_DRAG_TIME, 12'd100);
    send_touch_item(1'b1, 1'b1, rand_word());
    send_touch_item(1'b1, 1'b0, rand_word());
  endtask

  // long poll period: lock and drag land on widely spaced polls
  task automatic test_long_period();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_timing(12'd40, 12'd80, 12'd160);
    repeat (200) send_touch_item(1'b1, 1'b1, rand_word());
    repeat (50) send_touch_item(1'b1, 1'b0, rand_word());
  endtask

  // random settings, mostly clean press-hold-release runs, some bouncing
  task automatic test_random_gestures(input int strobe_budget, input int idle_pct,
                                      input int stall_pct);
    int  stop_at;
    int  chunk_end;
    int  hold_n;
    int  rel_n;
    bit  bouncy;
    bit  touch;
    logic [CFG_W-1:0] period;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = strobes_sent + strobe_budget;
    while (strobes_sent < stop_at) begin
      case ($urandom_range(9))
        0:       period = 12'd0;
        1:       period = POLL_PERIOD_RST;
        2, 3:    period = 12'd1;
        default: period = CFG_W'($urandom_range(2, 5));
      endcase
      set_timing(period, rand_hold_time(12), rand_hold_time(16));
      chunk_end = strobes_sent + 60;
      while (strobes_sent < chunk_end) begin
        hold_n = $urandom_range(1, 40);
        rel_n  = $urandom_range(1, 12);
        bouncy = ($urandom_range(9) == 0);
        for (int i = 0; i < hold_n + rel_n; i++) begin
          touch = (i < hold_n);
          if (bouncy) touch = 1'($urandom_range(1));
          // cycles without a strobe in between, touch flag is noise
          while ($urandom_range(3) == 0)
            send_touch_item(1'b0, 1'($urandom_range(1)), rand_word());
          send_touch_item(1'b1, touch, rand_word());
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_register_reset();
    test_directed_gestures();
    test_relock_after_retune();
    test_random_gestures(200, 7, 73);
    test_random_gestures(200, 73, 7);
    test_long_period();
    test_random_gestures(200, 0, 0);
    drain_results();
    $display("Sent %0d input transfers, %0d of them with a ms strobe.",
             items_sent, strobes_sent);
    $display("Gestures checked: pressed %0d, lock %0d, drag %0d, release %0d; errors %0d.",
             gestures_seen[GC_PRESSED], gestures_seen[GC_LOCK],
             gestures_seen[GC_DRAG], gestures_seen[GC_RELEASE], err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
